@@ rtl/bracket_balance_checker_assert.svh @@
// Assertion macros used by the checker file bbc_checker.sv.
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bbc_pkg.sv @@
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int KIND_W      = 2;

  localparam int SYM_W       = 8;
  localparam int CNT_W       = 20;
  localparam int STAT_W      = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int PAD_W       = OUT_TDATA_W - CNT_W - STAT_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(524288);

  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [SYM_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [SYM_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [SYM_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [SYM_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [SYM_W-1:0] CH_LANGLE = 8'h3C;
  localparam logic [SYM_W-1:0] CH_RANGLE = 8'h3E;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAREN = 2'd0,
    KIND_BRACK = 2'd1,
    KIND_BRACE = 2'd2,
    KIND_ANGLE = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_IMPOSSIBLE = 2'd1,
    ST_OVERFLOW   = 2'd2
  } status_t;

  typedef struct packed {
    logic       hit;
    kind_t      kind;
  } bracket_t;

  typedef struct packed {
    status_t              status;
    logic [CNT_W-1:0]     replacements;
  } result_t;

  function automatic bracket_t opener_decode(logic [SYM_W-1:0] c);
    bracket_t b;
    b.hit  = 1'b1;
    b.kind = KIND_PAREN;
    case (c)
      CH_LPAREN: b.kind = KIND_PAREN;
      CH_LBRACK: b.kind = KIND_BRACK;
      CH_LBRACE: b.kind = KIND_BRACE;
      CH_LANGLE: b.kind = KIND_ANGLE;
      default:   b.hit  = 1'b0;
    endcase
    return b;
  endfunction

  function automatic bracket_t closer_decode(logic [SYM_W-1:0] c);
    bracket_t b;
    b.hit  = 1'b1;
    b.kind = KIND_PAREN;
    case (c)
      CH_RPAREN: b.kind = KIND_PAREN;
      CH_RBRACK: b.kind = KIND_BRACK;
      CH_RBRACE: b.kind = KIND_BRACE;
      CH_RANGLE: b.kind = KIND_ANGLE;
      default:   b.hit  = 1'b0;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/bbc_ram.sv @@
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bbc_core.sv @@
`timescale 1ns / 1ps

module bbc_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [bbc_pkg::SYM_W-1:0]  symbol,
  input  logic                       last,
  output bbc_pkg::result_t           result
);

  logic [bbc_pkg::LVL_W-1:0]  level_r, level_upd, level_nxt;
  logic [bbc_pkg::CNT_W-1:0]  cnt_r, cnt_upd, cnt_nxt;
  logic                       fail_r, fail_upd, fail_nxt;
  logic                       ovf_r, ovf_upd, ovf_nxt;
  bbc_pkg::kind_t             top_r, top_nxt;
  logic                       byp_r;
  bbc_pkg::kind_t             byp_data_r;

  bbc_pkg::bracket_t          opener;
  bbc_pkg::bracket_t          closer;
  logic                       wr_en;
  logic [bbc_pkg::ADDR_W-1:0] wr_addr;
  logic [bbc_pkg::ADDR_W-1:0] rd_addr;
  logic [bbc_pkg::LVL_W-1:0]  lvl_dec;
  logic [bbc_pkg::LVL_W-1:0]  rd_lvl;
  logic [bbc_pkg::KIND_W-1:0] rd_data;
  bbc_pkg::kind_t             second;

  // top of stack lives in top_r; the RAM holds every entry below it
  bbc_ram #(
    .WIDTH (bbc_pkg::KIND_W),
    .DEPTH (bbc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (top_r),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign opener  = bbc_pkg::opener_decode(symbol);
  assign closer  = bbc_pkg::closer_decode(symbol);
  assign lvl_dec = level_r - bbc_pkg::LVL_W'(1);
  assign wr_addr = lvl_dec[bbc_pkg::ADDR_W-1:0];

  // forward the entry pushed last cycle; the RAM read of that address was stale
  assign second = byp_r ? byp_data_r : bbc_pkg::kind_t'(rd_data);

  always_comb begin
    level_upd = level_r;
    cnt_upd   = cnt_r;
    fail_upd  = fail_r;
    ovf_upd   = ovf_r;
    top_nxt   = top_r;
    wr_en     = 1'b0;
    if (step && !fail_r && !ovf_r) begin
      if (opener.hit) begin
        if (level_r == bbc_pkg::LVL_W'(bbc_pkg::STACK_DEPTH)) begin
          ovf_upd = 1'b1;
        end else begin
          wr_en     = (level_r != '0);
          top_nxt   = opener.kind;
          level_upd = level_r + bbc_pkg::LVL_W'(1);
        end
      end else if (level_r == '0) begin
        fail_upd = 1'b1;
      end else begin
        level_upd = lvl_dec;
        top_nxt   = second;
        if ((!closer.hit || closer.kind != top_r) && cnt_r < bbc_pkg::COUNT_MAX) begin
          cnt_upd = cnt_r + bbc_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    result.replacements = '0;
    if (ovf_upd) begin
      result.status = bbc_pkg::ST_OVERFLOW;
    end else if (fail_upd || level_upd != '0) begin
      result.status = bbc_pkg::ST_IMPOSSIBLE;
    end else begin
      result.status       = bbc_pkg::ST_OK;
      result.replacements = cnt_upd;
    end
  end

  // clear for the next string after the last beat
  always_comb begin
    level_nxt = level_upd;
    cnt_nxt   = cnt_upd;
    fail_nxt  = fail_upd;
    ovf_nxt   = ovf_upd;
    if (step && last) begin
      level_nxt = '0;
      cnt_nxt   = '0;
      fail_nxt  = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  // fetch the entry under the next top, ready for a pop next cycle
  assign rd_lvl  = level_nxt - bbc_pkg::LVL_W'(2);
  assign rd_addr = rd_lvl[bbc_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      cnt_r   <= '0;
      fail_r  <= 1'b0;
      ovf_r   <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      level_r <= level_nxt;
      cnt_r   <= cnt_nxt;
      fail_r  <= fail_nxt;
      ovf_r   <= ovf_nxt;
      byp_r   <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    byp_data_r <= top_r;
  end

endmodule

@@ rtl/bracket_balance_checker.sv @@
`timescale 1ns / 1ps

// Bracket balance checker. Takes one character per beat on in_tdata, with
// in_tlast on the final character of a string, and sustains one beat per
// clock except when result back-pressure stalls it. Openers ( [ { < are
// pushed on a 1024-entry stack (one single-port-write RAM plus a
// top-of-stack register); any other byte pops and counts a replacement
// when it is not the partner of the top. One result beat follows each
// string, its last beat passing the input register, then the result
// register: status 0 balanced with the saturating replacement count, 1
// impossible, 2 stack overflow, count 0 on failure. Back-pressure on the
// result side stalls input only when a new result has nowhere to go.
module bracket_balance_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bbc_pkg::SYM_W-1:0]        in_tdata,   // [7:0] symbol
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bbc_pkg::OUT_TDATA_W-1:0]  out_tdata   // [19:0] replacements, [21:20] status
);

  logic                          in_valid_r;
  logic [bbc_pkg::SYM_W-1:0]     in_sym_r;
  logic                          in_last_r;
  logic                          step;
  logic                          out_valid_r;
  logic [bbc_pkg::OUT_TDATA_W-1:0] out_data_r;
  bbc_pkg::result_t              result;

  assign step      = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_sym_r  <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  bbc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .symbol (in_sym_r),
    .last   (in_last_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      out_data_r <= {bbc_pkg::PAD_W'(0), result.status, result.replacements};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/bbc_checker.sv @@
`timescale 1ns / 1ps

`include "bracket_balance_checker_assert.svh"

module bbc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [bbc_pkg::SYM_W-1:0]        in_tdata,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bbc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic                         in_beat;
  logic [bbc_pkg::CNT_W-1:0]    repl;
  logic [bbc_pkg::STAT_W-1:0]   stat;

  assign in_beat = in_tvalid && in_tready && (in_tdata == in_tdata) && (in_tlast == in_tlast);
  assign repl    = out_tdata[bbc_pkg::CNT_W-1:0];
  assign stat    = out_tdata[bbc_pkg::CNT_W+bbc_pkg::STAT_W-1:bbc_pkg::CNT_W];

  `BBC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `BBC_ASSERT_IMP(a_status_code, out_tvalid, stat == bbc_pkg::ST_OK || stat == bbc_pkg::ST_IMPOSSIBLE || stat == bbc_pkg::ST_OVERFLOW, "unknown status code")
  `BBC_ASSERT_IMP(a_fail_count, out_tvalid && stat != bbc_pkg::ST_OK, repl == '0, "count nonzero on failed string")
  `BBC_ASSERT_IMP(a_count_sat, out_tvalid, repl <= bbc_pkg::COUNT_MAX, "count above saturation")
  `BBC_ASSERT_IMP(a_no_result_first, $past(!rst_n) && !in_beat, !out_tvalid, "result right after reset")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);
